/* src/per_device_error_stats_table_assert.svh */
// Assertion macros shared by the per-device error statistics RTL.
// Depends on nothing; users must have signals named clk and rst in scope.
`ifndef PER_DEVICE_ERROR_STATS_TABLE_ASSERT_SVH
`define PER_DEVICE_ERROR_STATS_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every edge outside reset
`define PDES_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pdes assertion failed");
// Same-cycle implication
`define PDES_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdes assertion failed");
// Next-cycle implication
`define PDES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdes assertion failed");
`else
`define PDES_ASSERT_ALWAYS(lbl, cond)
`define PDES_ASSERT_IMPL(lbl, ante, cons)
`define PDES_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/pdes_pkg.sv */
// Types and constants of the per-device error statistics table.
// Depends on nothing; used by every module of the block but pdes_ram.
package pdes_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int NUM_CATS    = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam logic [2:0] CAT_LIMIT = 3'(NUM_CATS);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Operation codes; out-of-range modes are folded into MODE_QUERY
  typedef enum logic [2:0] {
    MODE_ERROR     = 3'd0,
    MODE_SUCCESS   = 3'd1,
    MODE_RESET_DEV = 3'd2,
    MODE_RESET_ALL = 3'd3,
    MODE_QUERY     = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  device_address;
    logic [2:0]  category;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        found;
    logic        dropped;
    logic [31:0] crc_count;
    logic [31:0] timeout_count;
    logic [31:0] invalid_count;
    logic [31:0] device_fault_count;
    logic [31:0] other_count;
    logic [31:0] success_total;
    logic [31:0] last_error_ms;
    logic [31:0] error_sum;
    logic [4:0]  tracked_devices;
  } result_t;

  // One memory word: all counters of a slot
  typedef struct packed {
    logic [NUM_CATS-1:0][31:0] err;
    logic [31:0]               success;
    logic [31:0]               last_ms;
  } stats_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    mode_t            op;
    logic [IDX_W-1:0] slot;
    logic             found;
    logic             dropped;
    logic [2:0]       category;
    logic [31:0]      now_ms;
    logic [4:0]       tracked;
  } cmd_t;

endpackage

/* src/pdes_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pdes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, read port (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/pdes_front.sv */
// Front end: address lookup, slot allocation and item classification.
// Depends on pdes_pkg and the assertion macro header.
`include "per_device_error_stats_table_assert.svh"
module pdes_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pdes_pkg::item_t item,
  output logic           q_push,
  output pdes_pkg::cmd_t  q_cmd,
  input  logic           q_full
);
  import pdes_pkg::*;

  logic [MAX_ENTRIES-1:0] entry_used;
  logic [CNT_W-1:0]       entry_count;
  logic [7:0]             entry_address [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] hit;
  logic                   hit_any;
  logic [IDX_W-1:0]       hit_slot;
  logic [IDX_W-1:0]       new_slot;
  mode_t                  op;
  logic                   alloc_op;
  logic                   table_full;
  logic                   need_alloc;
  logic                   accept;
  logic [CNT_W-1:0]       count_after;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Parallel match over allocated slots; addresses are unique
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit[i] = entry_used[i] && (entry_address[i] == item.device_address);
      if (hit[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
      end
    end
    hit_any = |hit;
  end

  // Mode decode
  always_comb begin
    unique case (item.mode) inside
      MODE_ERROR:     op = MODE_ERROR;
      MODE_SUCCESS:   op = MODE_SUCCESS;
      MODE_RESET_DEV: op = MODE_RESET_DEV;
      MODE_RESET_ALL: op = MODE_RESET_ALL;
      default:        op = MODE_QUERY;
    endcase
    unique case (op) inside
      MODE_ERROR, MODE_SUCCESS, MODE_RESET_DEV: alloc_op = 1'b1;
      default:                                  alloc_op = 1'b0;
    endcase
  end

  assign table_full  = (entry_count == CNT_W'(MAX_ENTRIES));
  assign need_alloc  = alloc_op && !hit_any && !table_full;
  assign new_slot    = entry_count[IDX_W-1:0];
  assign count_after = need_alloc ? entry_count + CNT_W'(1) : entry_count;

  // Classified transaction
  always_comb begin
    q_cmd.op       = op;
    q_cmd.slot     = hit_any ? hit_slot : new_slot;
    q_cmd.found    = hit_any || need_alloc;
    q_cmd.dropped  = alloc_op && !hit_any && table_full;
    q_cmd.category = item.category;
    q_cmd.now_ms   = item.now_ms;
    q_cmd.tracked  = 5'(count_after);
  end
  assign q_push = accept;

  // Allocation state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_used  <= '0;
      entry_count <= '0;
    end else if (accept && need_alloc) begin
      entry_used[new_slot] <= 1'b1;
      entry_count          <= count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && need_alloc) begin
      entry_address[new_slot] <= item.device_address;
    end
  end

  `PDES_ASSERT_ALWAYS(a_count_bound, entry_count <= CNT_W'(MAX_ENTRIES))
  `PDES_ASSERT_NEXT(a_alloc_step, accept && need_alloc, entry_count == $past(entry_count) + 1'b1)

endmodule

/* src/pdes_cmd_fifo.sv */
// Short command queue that decouples classification from counter update.
// Depends on pdes_pkg and the assertion macro header.
`include "per_device_error_stats_table_assert.svh"
module pdes_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pdes_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output pdes_pkg::cmd_t  rd_data,
  output logic           empty
);
  import pdes_pkg::*;

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;

  assign full    = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `PDES_ASSERT_ALWAYS(a_fifo_bound, count <= CMDQ_CNT_W'(CMDQ_DEPTH))

endmodule

/* src/pdes_back.sv */
// Back end: counter read-modify-write on the stats memory and result register.
// Depends on pdes_pkg, pdes_ram and the assertion macro header.
`include "per_device_error_stats_table_assert.svh"
module pdes_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pdes_pkg::cmd_t    q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output pdes_pkg::result_t result
);
  import pdes_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } back_state_t;

  back_state_t            state;
  back_state_t            state_next;
  cmd_t                   cmd;
  logic [MAX_ENTRIES-1:0] zeroed;
  logic                   fwd_hit;
  stats_t                 fwd_data;
  logic                   out_valid;

  stats_t                 ram_rdata;
  stats_t                 ram_wdata;
  logic                   ram_we;
  logic                   take;
  logic                   out_ok;
  logic                   finish;
  stats_t                 old_stats;
  stats_t                 cur;
  stats_t                 rep;
  logic [31:0]            sum_cur;
  logic [31:0]            rep_sum;
  logic                   set_one;
  logic                   set_all;

  assign out_ok = !out_valid || pop;
  assign finish = (state == B_EXEC) && out_ok;
  assign take   = !q_empty && ((state == B_IDLE) || finish);
  assign q_pop  = take;
  assign empty  = !out_valid;

  // Counter memory, one word per slot
  pdes_ram #(
    .WIDTH($bits(stats_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_stats_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.slot),
    .wdata(ram_wdata),
    .re   (take),
    .raddr(q_data.slot),
    .rdata(ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (take) state_next = B_EXEC;
      B_EXEC: begin
        if (finish && !take) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Transaction in flight, plus bypass of a write to the slot being read
  always_ff @(posedge clk) begin
    if (take) begin
      cmd      <= q_data;
      fwd_hit  <= ram_we && (cmd.slot == q_data.slot);
      fwd_data <= ram_wdata;
    end
  end

  // Read-modify-write of the addressed slot
  always_comb begin
    old_stats = fwd_hit ? fwd_data : ram_rdata;
    cur       = zeroed[cmd.slot] ? '0 : old_stats;
    sum_cur   = '0;
    for (int c = 0; c < NUM_CATS; c++) begin
      sum_cur = sum_cur + cur.err[c];
    end
    ram_wdata = cur;
    rep       = cur;
    rep_sum   = sum_cur;
    ram_we    = 1'b0;
    set_one   = 1'b0;
    set_all   = 1'b0;
    unique case (cmd.op)
      MODE_ERROR: begin
        if (cmd.category < CAT_LIMIT) begin
          ram_wdata.err[cmd.category] = cur.err[cmd.category] + 32'd1;
          rep_sum = sum_cur + 32'd1;
        end
        ram_wdata.last_ms = cmd.now_ms;
        ram_we = finish && cmd.found;
        rep    = ram_wdata;
      end
      MODE_SUCCESS: begin
        ram_wdata.success = cur.success + 32'd1;
        ram_we = finish && cmd.found;
        rep    = ram_wdata;
      end
      MODE_RESET_DEV: begin
        set_one = finish && cmd.found;
        rep     = '0;
        rep_sum = '0;
      end
      MODE_RESET_ALL: begin
        set_all = finish;
        rep     = '0;
        rep_sum = '0;
      end
      default: begin
        rep = cur;
      end
    endcase
    if (!cmd.found) begin
      rep     = '0;
      rep_sum = '0;
    end
  end

  // Per-slot "reads as zero" flags; cleared by the first write after a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      zeroed <= '1;
    end else if (set_all) begin
      zeroed <= '1;
    end else if (set_one) begin
      zeroed[cmd.slot] <= 1'b1;
    end else if (ram_we) begin
      zeroed[cmd.slot] <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.found              <= cmd.found;
      result.dropped            <= cmd.dropped;
      result.crc_count          <= rep.err[0];
      result.timeout_count      <= rep.err[1];
      result.invalid_count      <= rep.err[2];
      result.device_fault_count <= rep.err[3];
      result.other_count        <= rep.err[4];
      result.success_total      <= rep.success;
      result.last_error_ms      <= rep.last_ms;
      result.error_sum          <= rep_sum;
      result.tracked_devices    <= cmd.tracked;
    end
  end

  `PDES_ASSERT_NEXT(a_stall_holds, (state == B_EXEC) && !out_ok, (state == B_EXEC) && $stable(cmd))
  `PDES_ASSERT_NEXT(a_reset_all_clears, finish && (cmd.op == MODE_RESET_ALL), &zeroed)
  `PDES_ASSERT_IMPL(a_write_needs_entry, ram_we, cmd.found && (state == B_EXEC))

endmodule

/* src/per_device_error_stats_table.sv */
// Per-device bus error statistics table: input queue port, result queue port.
// Depends on pdes_pkg, pdes_front, pdes_cmd_fifo and pdes_back.
//
// Usage:
//   Input: drive item and raise push; the transaction is taken on a clock
//   edge with push high and full low. Each item is record error, record
//   success, reset device, reset all or query for one 8-bit device address.
//   Results: while empty is low, result holds the oldest result; raise pop
//   to take it. Every item yields exactly one result, in order.
//   Path: an item passes the command queue, the back's transaction register
//   and the result register. Throughput: one item per cycle sustained while
//   pop keeps up; the front classifies and allocates as the item is taken,
//   the back reads the stats memory and writes it back as it finishes,
//   overlapping with the next read through a write bypass.
//   Reset (rst, synchronous): empties the table and both queues; no memory
//   clearing pass is needed, per-slot zero flags stand in for it.
//   Stall: if pop stays low the result register holds, the back stops, the
//   two-entry command queue fills and then full rises.
module per_device_error_stats_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pdes_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output pdes_pkg::result_t result
);
  import pdes_pkg::*;

  logic q_push;
  cmd_t q_wr_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_rd_cmd;
  logic q_empty;

  pdes_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .q_push(q_push),
    .q_cmd (q_wr_cmd),
    .q_full(q_full)
  );

  pdes_cmd_fifo u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd_cmd),
    .empty  (q_empty)
  );

  pdes_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_data (q_rd_cmd),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
